// File: hdl/fta_pkg.sv
// Shared types, widths and constants for the fan tachometer speed averager.
// Used by fta_ring, fta_div, fta_core and fan_tachometer_rpm_average.
package fta_pkg;

  localparam int MAX_WINDOW_DEF = 16;

  localparam int TIME_W  = 48;
  localparam int COUNT_W = 15;
  localparam int SPEED_W = 15;
  localparam int TOTAL_W = 19;
  localparam int LEN_W   = 5;
  localparam int SCALE_W = 26;
  localparam int PROD_W  = SCALE_W + COUNT_W;

  localparam logic [LEN_W-1:0]   WINDOW_RESET = 5'd16;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 26'd15000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX    = 15'h7FFF;
  localparam logic [15:0]        EDGE_MOD     = 16'd32767;
  localparam logic [15:0]        EDGE_MOD2    = 16'd65534;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  typedef struct packed {
    logic                 operation;
    logic [TIME_W-1:0]    timestamp_us;
    logic [COUNT_W-1:0]   pulse_count;
  } fta_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0]   average_rpm;
    logic [SPEED_W-1:0]   instant_rpm;
    logic [COUNT_W-1:0]   latest_count;
    logic                 speed_clipped;
  } fta_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]    time_us;
    logic [COUNT_W-1:0]   count;
    logic [SPEED_W-1:0]   speed;
  } fta_entry_t;

  typedef struct packed {
    logic [LEN_W-1:0]     window_length;
    logic [SCALE_W-1:0]   rpm_scale;
  } fta_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_W-1:0]    rem_init;
    logic [SPEED_W-1:0]   dividend;
    logic [TIME_W-1:0]    divisor;
  } fta_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [SPEED_W-1:0]   quotient;
  } fta_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CALC,
    ST_SAT,
    ST_DIV_SPD,
    ST_UPD,
    ST_AVG,
    ST_DIV_AVG,
    ST_DONE
  } fta_state_t;

endpackage

// File: hdl/fta_ring.sv
// Ring memory: one entry of time, edge count and speed per window slot.
// Synchronous write, registered read. Depends on fta_pkg.
module fta_ring #(
  parameter int MAX_WINDOW = fta_pkg::MAX_WINDOW_DEF
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [fta_pkg::idx_width(MAX_WINDOW)-1:0]     wr_addr,
  input  fta_pkg::fta_entry_t                           wr_data,
  input  logic                                          rd_en,
  input  logic [fta_pkg::idx_width(MAX_WINDOW)-1:0]     rd_addr,
  output fta_pkg::fta_entry_t                           rd_data
);

  fta_pkg::fta_entry_t mem [MAX_WINDOW];
  fta_pkg::fta_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/fta_div.sv
// Serial restoring divider, one quotient bit per cycle, 15 steps.
// Caller guarantees rem_init < divisor so the quotient fits 15 bits. Depends on fta_pkg.
module fta_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fta_pkg::fta_div_req_t req,
  output fta_pkg::fta_div_rsp_t rsp
);

  localparam int TW = fta_pkg::TIME_W;
  localparam int QW = fta_pkg::SPEED_W;
  localparam int CW = fta_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [TW-1:0] dvs_r, dvs_nxt;
  logic [TW:0]   trial;
  logic [TW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.rem_init;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[TW-1:0] : trial[TW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(fta_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: hdl/fta_core.sv
// Sequencer and datapath: ring read-modify-write, speed and average computation,
// entry valid bits and the output register. Depends on fta_pkg, fta_ring, fta_div.
module fta_core #(
  parameter int MAX_WINDOW = fta_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fta_pkg::fta_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  fta_pkg::fta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fta_pkg::fta_out_t out_data
);

  localparam int IDX_W   = fta_pkg::idx_width(MAX_WINDOW);
  localparam int LEN_W   = fta_pkg::LEN_W;
  localparam int MW      = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
  localparam int TIME_W  = fta_pkg::TIME_W;
  localparam int COUNT_W = fta_pkg::COUNT_W;
  localparam int SPEED_W = fta_pkg::SPEED_W;
  localparam int TOTAL_W = fta_pkg::TOTAL_W;
  localparam int PROD_W  = fta_pkg::PROD_W;

  fta_pkg::fta_state_t      state_r, state_nxt;
  logic [MAX_WINDOW-1:0]    vld_r, vld_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic [TIME_W-1:0]        prime_time_r, prime_time_nxt;
  logic [COUNT_W-1:0]       prime_count_r, prime_count_nxt;
  logic                     out_valid_r, out_valid_nxt;

  fta_pkg::fta_in_t         item_r, item_nxt;
  logic [MW-1:0]            mod_r, mod_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [TIME_W-1:0]        elapsed_r, elapsed_nxt;
  logic [SPEED_W-1:0]       old_speed_r, old_speed_nxt;
  logic [SPEED_W-1:0]       speed_r, speed_nxt;
  logic                     clip_r, clip_nxt;
  logic [SPEED_W-1:0]       avg_r, avg_nxt;
  fta_pkg::fta_out_t        out_data_r, out_data_nxt;

  logic [LEN_W-1:0]         eff_len;
  logic [IDX_W-1:0]         idx;
  logic                     accept;
  logic                     mod_ge;
  logic                     spd_zero;
  logic                     spd_sat;
  logic                     avg_sat;
  logic                     out_free;
  fta_pkg::fta_entry_t      rd_data;
  fta_pkg::fta_entry_t      old_entry;
  fta_pkg::fta_entry_t      wr_data;
  logic                     rd_en;
  logic                     wr_en;
  logic [15:0]              edge_diff;
  logic [COUNT_W-1:0]       edges;
  fta_pkg::fta_div_req_t    div_req;
  fta_pkg::fta_div_rsp_t    div_rsp;

  always_comb begin
    if (cfg.window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = cfg.window_length;
    end
  end

  assign idx      = mod_r[IDX_W-1:0];
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != fta_pkg::ST_IDLE);
  assign mod_ge   = mod_r >= MW'(eff_len);
  assign spd_zero = (elapsed_r == '0);
  assign spd_sat  = TIME_W'(prod_r[PROD_W-1:SPEED_W]) >= elapsed_r;
  assign avg_sat  = LEN_W'(total_r[TOTAL_W-1:SPEED_W]) >= eff_len;
  assign out_free = !out_valid_r || !out_stall;

  // unwritten slot reads as the primed time and count with speed zero
  always_comb begin
    if (vld_r[idx]) begin
      old_entry = rd_data;
    end else begin
      old_entry.time_us = prime_time_r;
      old_entry.count   = prime_count_r;
      old_entry.speed   = '0;
    end
  end

  // edges since the oldest slot, mod 32767
  assign edge_diff = fta_pkg::EDGE_MOD + 16'(item_r.pulse_count) - 16'(old_entry.count);
  always_comb begin
    if (edge_diff >= fta_pkg::EDGE_MOD2) begin
      edges = '0;
    end else if (edge_diff >= fta_pkg::EDGE_MOD) begin
      edges = COUNT_W'(edge_diff - fta_pkg::EDGE_MOD);
    end else begin
      edges = edge_diff[COUNT_W-1:0];
    end
  end

  assign rd_en           = (state_r == fta_pkg::ST_READ);
  assign wr_en           = (state_r == fta_pkg::ST_UPD);
  assign wr_data.time_us = item_r.timestamp_us;
  assign wr_data.count   = item_r.pulse_count;
  assign wr_data.speed   = speed_r;

  always_comb begin
    div_req = '0;
    if (state_r == fta_pkg::ST_SAT && !spd_zero && !spd_sat) begin
      div_req.start    = 1'b1;
      div_req.rem_init = TIME_W'(prod_r[PROD_W-1:SPEED_W]);
      div_req.dividend = prod_r[SPEED_W-1:0];
      div_req.divisor  = elapsed_r;
    end else if (state_r == fta_pkg::ST_AVG && !avg_sat) begin
      div_req.start    = 1'b1;
      div_req.rem_init = TIME_W'(total_r[TOTAL_W-1:SPEED_W]);
      div_req.dividend = total_r[SPEED_W-1:0];
      div_req.divisor  = TIME_W'(eff_len);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fta_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == fta_pkg::OP_START) ? fta_pkg::ST_DONE
                                                              : fta_pkg::ST_MOD;
        end
      end
      fta_pkg::ST_MOD: begin
        if (!mod_ge) begin
          state_nxt = fta_pkg::ST_READ;
        end
      end
      fta_pkg::ST_READ:    state_nxt = fta_pkg::ST_CALC;
      fta_pkg::ST_CALC:    state_nxt = fta_pkg::ST_SAT;
      fta_pkg::ST_SAT: begin
        state_nxt = (spd_zero || spd_sat) ? fta_pkg::ST_UPD : fta_pkg::ST_DIV_SPD;
      end
      fta_pkg::ST_DIV_SPD: begin
        if (div_rsp.done) begin
          state_nxt = fta_pkg::ST_UPD;
        end
      end
      fta_pkg::ST_UPD:     state_nxt = fta_pkg::ST_AVG;
      fta_pkg::ST_AVG: begin
        state_nxt = avg_sat ? fta_pkg::ST_DONE : fta_pkg::ST_DIV_AVG;
      end
      fta_pkg::ST_DIV_AVG: begin
        if (div_rsp.done) begin
          state_nxt = fta_pkg::ST_DONE;
        end
      end
      fta_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fta_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = fta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    vld_nxt         = vld_r;
    pos_nxt         = pos_r;
    total_nxt       = total_r;
    prime_time_nxt  = prime_time_r;
    prime_count_nxt = prime_count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    item_nxt        = item_r;
    mod_nxt         = mod_r;
    prod_nxt        = prod_r;
    elapsed_nxt     = elapsed_r;
    old_speed_nxt   = old_speed_r;
    speed_nxt       = speed_r;
    clip_nxt        = clip_r;
    avg_nxt         = avg_r;
    out_data_nxt    = out_data_r;
    unique case (state_r)
      fta_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          mod_nxt  = MW'(pos_r) + MW'(1);
          if (in_data.operation == fta_pkg::OP_START) begin
            vld_nxt         = '0;
            pos_nxt         = '0;
            total_nxt       = '0;
            prime_time_nxt  = in_data.timestamp_us;
            prime_count_nxt = in_data.pulse_count;
            speed_nxt       = '0;
            clip_nxt        = 1'b0;
            avg_nxt         = '0;
          end
        end
      end
      fta_pkg::ST_MOD: begin
        if (mod_ge) begin
          mod_nxt = mod_r - MW'(eff_len);
        end
      end
      fta_pkg::ST_READ: begin
      end
      fta_pkg::ST_CALC: begin
        elapsed_nxt   = item_r.timestamp_us - old_entry.time_us;
        prod_nxt      = PROD_W'(cfg.rpm_scale) * PROD_W'(edges);
        old_speed_nxt = old_entry.speed;
      end
      fta_pkg::ST_SAT: begin
        if (spd_zero) begin
          speed_nxt = '0;
          clip_nxt  = 1'b1;
        end else if (spd_sat) begin
          speed_nxt = fta_pkg::SPEED_MAX;
          clip_nxt  = 1'b1;
        end else begin
          clip_nxt  = 1'b0;
        end
      end
      fta_pkg::ST_DIV_SPD: begin
        if (div_rsp.done) begin
          speed_nxt = div_rsp.quotient;
        end
      end
      fta_pkg::ST_UPD: begin
        total_nxt    = total_r - TOTAL_W'(old_speed_r) + TOTAL_W'(speed_r);
        vld_nxt[idx] = 1'b1;
        pos_nxt      = idx;
      end
      fta_pkg::ST_AVG: begin
        if (avg_sat) begin
          avg_nxt = fta_pkg::SPEED_MAX;
        end
      end
      fta_pkg::ST_DIV_AVG: begin
        if (div_rsp.done) begin
          avg_nxt = div_rsp.quotient;
        end
      end
      fta_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.average_rpm   = avg_r;
          out_data_nxt.instant_rpm   = speed_r;
          out_data_nxt.latest_count  = item_r.pulse_count;
          out_data_nxt.speed_clipped = clip_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fta_pkg::ST_IDLE;
      vld_r         <= '0;
      pos_r         <= '0;
      total_r       <= '0;
      prime_time_r  <= '0;
      prime_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      vld_r         <= vld_nxt;
      pos_r         <= pos_nxt;
      total_r       <= total_nxt;
      prime_time_r  <= prime_time_nxt;
      prime_count_r <= prime_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    mod_r       <= mod_nxt;
    prod_r      <= prod_nxt;
    elapsed_r   <= elapsed_nxt;
    old_speed_r <= old_speed_nxt;
    speed_r     <= speed_nxt;
    clip_r      <= clip_nxt;
    avg_r       <= avg_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fta_ring #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  fta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// File: hdl/fan_tachometer_rpm_average.sv
// Sample item: ST_MOD, ST_READ, ST_CALC, ST_SAT, serial speed division, ST_UPD, ST_AVG,
// serial average division, ST_DONE; zero elapsed time or a saturated speed skips the first
// division, a saturated average the second. Each ring-index reduction (wrap to slot 0, or
// window shortened without a start) adds an ST_MOD pass. Start item: ST_DONE only. One item
// at a time: the next is taken the cycle after the result enters the output register.
// Reset (sync, rst_n low): window 16, scale 15000000, slots unwritten; needs fta_pkg, fta_core.
module fan_tachometer_rpm_average #(
  parameter int MAX_WINDOW = fta_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fta_pkg::fta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fta_pkg::fta_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SCALE  = 1'b1;

  logic [fta_pkg::LEN_W-1:0]   window_r, window_nxt;
  logic [fta_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic                        cfg_wr;
  fta_pkg::fta_cfg_t           cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    window_nxt = window_r;
    scale_nxt  = scale_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_WINDOW: window_nxt = cfg_pwdata[fta_pkg::LEN_W-1:0];
        REG_SCALE:  scale_nxt  = cfg_pwdata[fta_pkg::SCALE_W-1:0];
        default:    window_nxt = window_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WINDOW: cfg_prdata = 32'(window_r);
      REG_SCALE:  cfg_prdata = 32'(scale_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= fta_pkg::WINDOW_RESET;
      scale_r  <= fta_pkg::SCALE_RESET;
    end else begin
      window_r <= window_nxt;
      scale_r  <= scale_nxt;
    end
  end

  assign cfg.window_length = window_r;
  assign cfg.rpm_scale     = scale_r;

  fta_core #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in flight");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.speed_clipped |->
      out_data.instant_rpm == '0 || out_data.instant_rpm == fta_pkg::SPEED_MAX)
    else $error("clipped speed is neither zero nor saturated");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && in_data.operation == fta_pkg::OP_START
      |=> ##1 (out_valid && out_data.average_rpm == '0 && out_data.instant_rpm == '0 &&
               out_data.latest_count == $past(in_data.pulse_count, 2)))
    else $error("start item result wrong or late");
`endif

endmodule

// File: tb/rpm_average_checker.sv
// Checker for fan_tachometer_rpm_average: follows register writes and accepted items,
// predicts each result and compares it field by field. Depends on fta_pkg.
module rpm_average_checker #(
  parameter logic [2:0] WINDOW_ADDR = 3'd0,
  parameter logic [2:0] SCALE_ADDR  = 3'd4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  fta_pkg::fta_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  fta_pkg::fta_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending_results
);

  localparam int LEN_W   = fta_pkg::LEN_W;
  localparam int SCALE_W = fta_pkg::SCALE_W;
  localparam int TIME_W  = fta_pkg::TIME_W;
  localparam int COUNT_W = fta_pkg::COUNT_W;
  localparam int SPEED_W = fta_pkg::SPEED_W;
  localparam int TOTAL_W = fta_pkg::TOTAL_W;
  localparam int DEPTH   = fta_pkg::MAX_WINDOW_DEF;

  logic [LEN_W-1:0]   win_len;
  logic [SCALE_W-1:0] scale;
  logic [TIME_W-1:0]  slot_time  [DEPTH];
  logic [COUNT_W-1:0] slot_count [DEPTH];
  logic [SPEED_W-1:0] slot_speed [DEPTH];
  bit                 slot_used  [DEPTH];
  logic [TIME_W-1:0]  primed_time;
  logic [COUNT_W-1:0] primed_count;
  int unsigned        cursor;
  logic [TOTAL_W-1:0] total;
  fta_pkg::fta_out_t  expected_rpm [$];

  function automatic fta_pkg::fta_out_t predict_rpm(input fta_pkg::fta_in_t item);
    fta_pkg::fta_out_t res;
    int unsigned       span, slot, base_count, old_speed, edges, speed, avg;
    logic [TIME_W-1:0] base_time, elapsed;
    longint unsigned   quot;
    res = '0;
    res.latest_count = item.pulse_count;
    if (item.operation == fta_pkg::OP_START) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      primed_time = item.timestamp_us;
      primed_count = item.pulse_count;
      cursor = 0;
      total = '0;
      return res;
    end
    if (win_len == '0) span = 1;
    else if (32'(win_len) > 32'(DEPTH)) span = DEPTH;
    else span = 32'(win_len);
    slot = (cursor + 1) % span;
    if (slot_used[slot]) begin
      base_time = slot_time[slot];
      base_count = 32'(slot_count[slot]);
      old_speed = 32'(slot_speed[slot]);
    end else begin
      base_time = primed_time;
      base_count = 32'(primed_count);
      old_speed = 0;
    end
    edges = (32'(fta_pkg::EDGE_MOD) + 32'(item.pulse_count) - base_count) %
            32'(fta_pkg::EDGE_MOD);
    elapsed = item.timestamp_us - base_time;
    if (elapsed == '0) begin
      speed = 0;
      res.speed_clipped = 1'b1;
    end else begin
      quot = (64'(scale) * 64'(edges)) / 64'(elapsed);
      if (quot > 64'(fta_pkg::SPEED_MAX)) begin
        speed = 32'(fta_pkg::SPEED_MAX);
        res.speed_clipped = 1'b1;
      end else begin
        speed = 32'(quot);
      end
    end
    total = TOTAL_W'(32'(total) - old_speed + speed);
    slot_time[slot] = item.timestamp_us;
    slot_count[slot] = item.pulse_count;
    slot_speed[slot] = SPEED_W'(speed);
    slot_used[slot] = 1'b1;
    cursor = slot;
    avg = 32'(total) / span;
    if (avg > 32'(fta_pkg::SPEED_MAX)) avg = 32'(fta_pkg::SPEED_MAX);
    res.average_rpm = SPEED_W'(avg);
    res.instant_rpm = SPEED_W'(speed);
    return res;
  endfunction

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    fta_pkg::fta_out_t want;
    if (!rst_n) begin
      win_len = fta_pkg::WINDOW_RESET;
      scale = fta_pkg::SCALE_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      primed_time = '0;
      primed_count = '0;
      cursor = 0;
      total = '0;
      expected_rpm.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          WINDOW_ADDR: win_len = cfg_pwdata[LEN_W-1:0];
          SCALE_ADDR:  scale = cfg_pwdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_rpm.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, got avg %0d inst %0d count %0d clip %0b",
                   $time, out_data.average_rpm, out_data.instant_rpm,
                   out_data.latest_count, out_data.speed_clipped);
        end else begin
          want = expected_rpm.pop_front();
          if (out_data.average_rpm !== want.average_rpm)
            report("average_rpm", 32'(want.average_rpm), 32'(out_data.average_rpm));
          if (out_data.instant_rpm !== want.instant_rpm)
            report("instant_rpm", 32'(want.instant_rpm), 32'(out_data.instant_rpm));
          if (out_data.latest_count !== want.latest_count)
            report("latest_count", 32'(want.latest_count), 32'(out_data.latest_count));
          if (out_data.speed_clipped !== want.speed_clipped)
            report("speed_clipped", 32'(want.speed_clipped), 32'(out_data.speed_clipped));
        end
      end
      if (in_valid && !in_stall) expected_rpm.push_back(predict_rpm(in_data));
    end
    pending_results = expected_rpm.size();
  end

endmodule

// File: tb/fan_tachometer_rpm_average_test.sv
// Top of the fan_tachometer_rpm_average testbench: clock, reset, register writes, item
// stimulus and result-side stalls. Checking is done in rpm_average_checker.
module fan_tachometer_rpm_average_test;

  localparam int         TIME_W       = fta_pkg::TIME_W;
  localparam int         COUNT_W      = fta_pkg::COUNT_W;
  localparam int         LEN_W        = fta_pkg::LEN_W;
  localparam int         SCALE_W      = fta_pkg::SCALE_W;
  localparam logic [2:0] REG_WINDOW   = 3'd0;
  localparam logic [2:0] REG_SCALE    = 3'd4;
  localparam int         RANDOM_ITEMS = 1300;
  localparam int         PLAN_LEN     = 8;
  localparam int         TAIL_CYCLES  = 60;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  fta_pkg::fta_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  fta_pkg::fta_out_t out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending_results;

  bit                 tx_gaps = 1'b1;
  bit                 rx_gaps = 1'b1;
  logic [TIME_W-1:0]  cur_time;
  logic [COUNT_W-1:0] cur_count;
  int                 n_items;
  int                 n_starts;
  int                 n_random;
  int                 n_settings;

  int unsigned window_plan [PLAN_LEN] = '{16, 1, 0, 31, 5, 16, 3, 2};
  int unsigned scale_plan  [PLAN_LEN] = '{67108863, 67108863, 15000000, 1, 0, 60000000,
                                          15000000, 30000000};
  bit          prime_plan  [PLAN_LEN] = '{1, 0, 1, 1, 1, 1, 0, 1};

  fan_tachometer_rpm_average u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  rpm_average_checker #(.WINDOW_ADDR(REG_WINDOW), .SCALE_ADDR(REG_SCALE)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always #2 clk = ~clk;

  initial begin
    #3000000;
    $display("fan_tachometer_rpm_average_test NOT OK");
    $finish;
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = rx_gaps ? int'($urandom_range(0, 7)) : 0;
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  task automatic send_item(input logic op, input logic [TIME_W-1:0] ts,
                           input logic [COUNT_W-1:0] cnt);
    int gap;
    gap = tx_gaps ? int'($urandom_range(0, 7)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, timestamp_us: ts, pulse_count: cnt};
    do @(posedge clk); while (!(in_valid && !in_stall));
    n_items++;
    if (op == fta_pkg::OP_START) n_starts++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic prime_stream();
    cur_time = rand_time();
    cur_count = COUNT_W'($urandom_range(0, 32767));
    send_item(fta_pkg::OP_START, cur_time, cur_count);
  endtask

  // mostly consistent time/count progressions, some restarts and pure noise
  task automatic next_stream_item();
    int unsigned       pick, dc;
    logic [TIME_W-1:0] dt;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      prime_stream();
    end else if (pick < 16) begin
      send_item(1'($urandom_range(0, 1)), rand_time(), COUNT_W'($urandom_range(0, 32767)));
    end else begin
      case ($urandom_range(0, 9))
        0:       dt = '0;
        1:       dt = TIME_W'($urandom_range(1, 50));
        8:       dt = TIME_W'($urandom_range(50000, 2000000));
        9:       dt = rand_time();
        default: dt = TIME_W'($urandom_range(500, 50000));
      endcase
      case ($urandom_range(0, 9))
        0:       dc = 0;
        1:       dc = $urandom_range(0, 32766);
        default: dc = $urandom_range(0, 400);
      endcase
      cur_time = cur_time + dt;
      cur_count = COUNT_W'((32'(cur_count) + dc) % 32'(fta_pkg::EDGE_MOD));
      if (cur_count == '0 && $urandom_range(0, 1) == 1) cur_count = '1;
      send_item(fta_pkg::OP_SAMPLE, cur_time, cur_count);
    end
    n_random++;
    if ($urandom_range(0, 63) == 0) drain_results();
  endtask

  initial begin
    int unsigned phase, win, sc, junk;
    bit          prime;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    n_items = 0;
    n_starts = 0;
    n_random = 0;
    n_settings = 1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: sample before any start, zero elapsed, saturation, wraps
    send_item(fta_pkg::OP_SAMPLE, 48'd1000, 15'd5);
    send_item(fta_pkg::OP_START, 48'd0, 15'd0);
    send_item(fta_pkg::OP_SAMPLE, 48'd0, 15'd10);
    send_item(fta_pkg::OP_SAMPLE, 48'd1, 15'd32766);
    send_item(fta_pkg::OP_START, 48'hFFFF_FFFF_FFFB, 15'h7FFF);
    send_item(fta_pkg::OP_SAMPLE, 48'd10, 15'd5);
    send_item(fta_pkg::OP_SAMPLE, 48'hFFFF_FFFF_FFFF, 15'h7FFF);
    cur_time = 48'd100000;
    cur_count = 15'd200;
    repeat (6) begin
      cur_time = cur_time + TIME_W'(20000);
      cur_count = cur_count + COUNT_W'(80);
      send_item(fta_pkg::OP_SAMPLE, cur_time, cur_count);
    end
    // shrink the window without a start
    drain_results();
    write_reg(REG_WINDOW, 32'd4);
    n_settings++;
    repeat (3) begin
      cur_time = cur_time + TIME_W'(20000);
      cur_count = cur_count + COUNT_W'(80);
      send_item(fta_pkg::OP_SAMPLE, cur_time, cur_count);
    end
    drain_results();
    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_SCALE, 32'd60000000);
    n_settings++;
    send_item(fta_pkg::OP_START, cur_time, cur_count);
    repeat (3) begin
      cur_time = cur_time + TIME_W'(1500);
      cur_count = cur_count + COUNT_W'(3);
      send_item(fta_pkg::OP_SAMPLE, cur_time, cur_count);
    end
    drain_results();
    write_reg(REG_SCALE, 32'd0);
    n_settings++;
    repeat (2) begin
      cur_time = cur_time + TIME_W'(1000);
      cur_count = cur_count + COUNT_W'(50);
      send_item(fta_pkg::OP_SAMPLE, cur_time, cur_count);
    end

    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      drain_results();
      if (phase < PLAN_LEN) begin
        win = window_plan[phase];
        sc = scale_plan[phase];
        prime = prime_plan[phase];
      end else begin
        win = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        case ($urandom_range(0, 2))
          0:       sc = $urandom_range(0, 67108863);
          1:       sc = $urandom_range(1, 60000000);
          default: sc = $urandom_range(1000000, 30000000);
        endcase
        prime = $urandom_range(0, 4) != 0;
      end
      junk = phase[0] ? $urandom : 0;
      write_reg(REG_WINDOW, win | (junk << LEN_W));
      write_reg(REG_SCALE, sc | (junk << SCALE_W));
      n_settings++;
      tx_gaps = (phase % 4) != 3;
      rx_gaps = (phase % 3) != 0;
      if (prime) prime_stream();
      repeat (90 + $urandom_range(0, 30)) next_stream_item();
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d items (%0d starts) over %0d register settings,", n_items, n_starts,
             n_settings);
    $display("including window extremes, scale extremes and unprimed window changes.");
    if (fail_count == 0 && pending_results == 0)
      $display("fan_tachometer_rpm_average_test OK");
    else
      $display("fan_tachometer_rpm_average_test NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/fta_pkg.sv
hdl/fta_ring.sv
hdl/fta_div.sv
hdl/fta_core.sv
hdl/fan_tachometer_rpm_average.sv
tb/rpm_average_checker.sv
tb/fan_tachometer_rpm_average_test.sv
